@@ src/tpa_pkg.sv @@
package tpa_pkg;

	// topology codes (glTF primitive mode)
	localparam logic [2:0] MODE_LIST  = 3'd4;
	localparam logic [2:0] MODE_STRIP = 3'd5;
	localparam logic [2:0] MODE_FAN   = 3'd6;

	// configuration register indexes
	localparam logic [1:0] CFG_TOPOLOGY_MODE = 2'd0;
	localparam logic [1:0] CFG_WINDING_FLIP  = 2'd1;
	localparam logic [1:0] CFG_VTX_LIMIT     = 2'd2;
	localparam logic [1:0] CFG_VERTEX_BASE   = 2'd3;

	localparam int CORNER_BITS = 32;

	typedef struct packed {
		logic [2:0]             mode;
		logic                   flip;
		logic [CORNER_BITS-1:0] count;
		logic [CORNER_BITS-1:0] base;
	} tpa_cfg_t;

	typedef struct packed {
		logic                   err;
		logic [CORNER_BITS-1:0] a;
		logic [CORNER_BITS-1:0] b;
		logic [CORNER_BITS-1:0] c;
	} tpa_result_t;

endpackage

@@ src/tpa_fifo.sv @@
module tpa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// DEPTH is a power of two, pointers wrap naturally
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ src/tpa_front.sv @@
module tpa_front #(
	parameter int INDEX_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tpa_pkg::tpa_cfg_t       cfg,
	input  logic                    in_acc,
	input  logic [INDEX_BITS-1:0]   idx,
	input  logic                    first,
	output logic                    req_push,
	output logic [3*INDEX_BITS:0]   req_data
);
	import tpa_pkg::*;

	logic [1:0]            seen_q, seen_e, seen_n;
	logic [1:0]            phase_q, phase_e, phase_n;
	logic                  parity_q, parity_e, parity_n;
	logic                  err_q, err_e, err_n;
	logic [INDEX_BITS-1:0] anchor_q, anchor_e, anchor_n;
	logic [INDEX_BITS-1:0] older_q, older_e, older_n;
	logic [INDEX_BITS-1:0] newer_q, newer_e, newer_n;
	logic                  emit, rec_err;
	logic [INDEX_BITS-1:0] ra, rb, rc;

	always_comb begin
		// start of primitive wipes the assembly state first
		seen_e   = first ? '0 : seen_q;
		phase_e  = first ? '0 : phase_q;
		parity_e = first ? 1'b0 : parity_q;
		err_e    = first ? 1'b0 : err_q;
		anchor_e = first ? '0 : anchor_q;
		older_e  = first ? '0 : older_q;
		newer_e  = first ? '0 : newer_q;

		seen_n   = seen_e;
		phase_n  = phase_e;
		parity_n = parity_e;
		err_n    = err_e;
		anchor_n = anchor_e;
		older_n  = older_e;
		newer_n  = newer_e;
		emit     = 1'b0;
		rec_err  = 1'b0;
		ra       = '0;
		rb       = '0;
		rc       = '0;

		if ((cfg.mode inside {MODE_LIST, MODE_STRIP, MODE_FAN}) && !err_e) begin
			if (CORNER_BITS'(idx) >= cfg.count) begin
				err_n   = 1'b1;
				emit    = 1'b1;
				rec_err = 1'b1;
			end else begin
				case (cfg.mode)
					MODE_LIST: begin
						if (phase_e == 2'd0) begin
							older_n = idx;
							phase_n = 2'd1;
						end else if (phase_e == 2'd1) begin
							newer_n = idx;
							phase_n = 2'd2;
						end else begin
							phase_n = 2'd0;
							emit    = 1'b1;
							ra      = older_e;
							rb      = newer_e;
							rc      = idx;
						end
					end
					MODE_STRIP: begin
						if (seen_e == 2'd0) begin
							older_n = idx;
							seen_n  = 2'd1;
						end else if (seen_e == 2'd1) begin
							newer_n = idx;
							seen_n  = 2'd2;
						end else begin
							// odd strip triangles swap the first two corners
							emit     = 1'b1;
							ra       = parity_e ? newer_e : older_e;
							rb       = parity_e ? older_e : newer_e;
							rc       = idx;
							parity_n = !parity_e;
							older_n  = newer_e;
							newer_n  = idx;
						end
					end
					default: begin
						// fan
						if (seen_e == 2'd0) begin
							anchor_n = idx;
							seen_n   = 2'd1;
						end else if (seen_e == 2'd1) begin
							newer_n = idx;
							seen_n  = 2'd2;
						end else begin
							emit    = 1'b1;
							ra      = anchor_e;
							rb      = newer_e;
							rc      = idx;
							older_n = newer_e;
							newer_n = idx;
						end
					end
				endcase
			end
		end
	end

	assign req_push = in_acc && emit;
	assign req_data = {rec_err, ra, rb, rc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			phase_q  <= '0;
			parity_q <= 1'b0;
			err_q    <= 1'b0;
			anchor_q <= '0;
			older_q  <= '0;
			newer_q  <= '0;
		end else if (in_acc) begin
			seen_q   <= seen_n;
			phase_q  <= phase_n;
			parity_q <= parity_n;
			err_q    <= err_n;
			anchor_q <= anchor_n;
			older_q  <= older_n;
			newer_q  <= newer_n;
		end
	end

endmodule

@@ src/tpa_back.sv @@
module tpa_back #(
	parameter int INDEX_BITS = 32
) (
	input  tpa_pkg::tpa_cfg_t     cfg,
	input  logic                  req_empty,
	input  logic [3*INDEX_BITS:0] req_data,
	output logic                  req_pop,
	input  logic                  res_full,
	output logic                  res_push,
	output tpa_pkg::tpa_result_t  res_data
);
	import tpa_pkg::*;

	logic                  r_err, degen;
	logic [INDEX_BITS-1:0] r_a, r_b, r_c, fb, fc;

	assign {r_err, r_a, r_b, r_c} = req_data;

	// winding flip swaps the second and third corner
	assign fb    = cfg.flip ? r_c : r_b;
	assign fc    = cfg.flip ? r_b : r_c;
	assign degen = (r_a == fb) || (fb == fc) || (fc == r_a);

	// degenerate requests are consumed without a result
	assign req_pop  = !req_empty && !res_full;
	assign res_push = req_pop && (r_err || !degen);

	always_comb begin
		res_data.err = r_err;
		if (r_err) begin
			res_data.a = '0;
			res_data.b = '0;
			res_data.c = '0;
		end else begin
			res_data.a = CORNER_BITS'(r_a) + cfg.base;
			res_data.b = CORNER_BITS'(fb) + cfg.base;
			res_data.c = CORNER_BITS'(fc) + cfg.base;
		end
	end

endmodule

@@ src/triangle_primitive_assembly_top.sv @@
// Triangle primitive assembly. Vertex indices come in through a queue-style
// port (push/full) and triangles leave through another (empty/pop). The
// topology follows glTF: 4 list, 5 strip (odd triangles swap the first two
// corners), 6 fan (anchored on the first index); any other mode produces
// nothing. first_of_primitive restarts assembly and clears the error mark.
// An index at or above the vertex limit register gives one result with
// index_error set and zero corners, then the block stays silent until the
// next primitive.
// Triangles with two equal corners are dropped; vertex_base is added to
// every corner modulo 2^32. Only the low INDEX_BITS bits of an index count.
// Throughput is one index per clock while full is low; the front assembly
// step and the back flip/degenerate-check/base-add step are combinational.
// A finished triangle passes through the request queue and then the result
// queue before it shows on the result ports. A 4-deep queue sits between
// front and back, a 2-deep queue holds finished results, so either side may
// stall without blocking the other until the queues fill. Configuration
// writes (cfg_valid, index, data) are always taken (cfg_ready is tied high)
// and must only happen while the block is idle.
module triangle_primitive_assembly_top #(
	parameter int INDEX_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// index input queue
	input  logic        push,
	output logic        full,
	input  logic [31:0] index_value,
	input  logic        first_of_primitive,
	// result queue
	output logic        empty,
	input  logic        pop,
	output logic [31:0] corner_a,
	output logic [31:0] corner_b,
	output logic [31:0] corner_c,
	output logic        index_error,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import tpa_pkg::*;

	localparam int REQ_BITS = 3 * INDEX_BITS + 1;
	localparam int REQ_DEPTH = 4;
	localparam int RES_DEPTH = 2;

	tpa_cfg_t              cfg_q;
	logic                  in_acc;
	logic                  req_push, req_full, req_empty, req_pop;
	logic [REQ_BITS-1:0]   req_wdata, req_rdata;
	logic                  res_push, res_full;
	tpa_result_t           res_wdata, res_rdata;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= MODE_LIST;
			cfg_q.flip  <= 1'b0;
			cfg_q.count <= '0;
			cfg_q.base  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TOPOLOGY_MODE: cfg_q.mode  <= cfg_data[2:0];
				CFG_WINDING_FLIP:  cfg_q.flip  <= cfg_data[0];
				CFG_VTX_LIMIT:     cfg_q.count <= cfg_data;
				CFG_VERTEX_BASE:   cfg_q.base  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front accepts whenever the request queue has room
	assign full   = req_full;
	assign in_acc = push && !req_full;

	tpa_front #(.INDEX_BITS(INDEX_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_acc   (in_acc),
		.idx      (index_value[INDEX_BITS-1:0]),
		.first    (first_of_primitive),
		.req_push (req_push),
		.req_data (req_wdata)
	);

	tpa_fifo #(.WIDTH(REQ_BITS), .DEPTH(REQ_DEPTH)) u_req_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (req_push),
		.wr_data (req_wdata),
		.full    (req_full),
		.rd_en   (req_pop),
		.rd_data (req_rdata),
		.empty   (req_empty)
	);

	tpa_back #(.INDEX_BITS(INDEX_BITS)) u_back (
		.cfg       (cfg_q),
		.req_empty (req_empty),
		.req_data  (req_rdata),
		.req_pop   (req_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_wdata)
	);

	tpa_fifo #(.WIDTH($bits(tpa_result_t)), .DEPTH(RES_DEPTH)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wdata),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_rdata),
		.empty   (empty)
	);

	assign corner_a    = res_rdata.a;
	assign corner_b    = res_rdata.b;
	assign corner_c    = res_rdata.c;
	assign index_error = res_rdata.err;

endmodule

@@ src/tpa_checker.sv @@
module tpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [31:0] corner_a,
	input logic [31:0] corner_b,
	input logic [31:0] corner_c,
	input logic        index_error,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// error results carry zero corners
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && index_error |-> corner_a == 32'd0 && corner_b == 32'd0 && corner_c == 32'd0)
		else $error("error result with nonzero corners");

	// degenerate triangles never leave the block
	a_no_degen: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !index_error |->
			corner_a != corner_b && corner_b != corner_c && corner_c != corner_a)
		else $error("degenerate triangle emitted");

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(corner_a) && $stable(index_error))
		else $error("waiting result changed");

	// configuration channel never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind triangle_primitive_assembly_top tpa_checker u_tpa_checker (.*);

@@ test/triangle_primitive_assembly_top_tb.sv @@
`timescale 1ns / 1ps

module triangle_primitive_assembly_top_tb;
	import tpa_pkg::*;

	localparam int INDEX_BITS     = 32;
	localparam int RANDOM_ITEMS   = 1600;
	localparam int SETTLE_CYCLES  = 16;   // covers front + back + both queues
	localparam int WATCHDOG_LIMIT = 3000; // cycles with no handshake at all

	// Scoreboard: tracks register contents and assembly state, turns each
	// accepted index into the triangle (or error) it should produce, and checks
	// popped results against the oldest pending one.
	class triangle_board;
		logic [2:0]  mode;
		logic        flip;
		logic [31:0] vcount;
		logic [31:0] vbase;

		logic [1:0]  seen;
		logic [1:0]  phase;
		logic        parity;
		logic        err_mark;
		logic [31:0] anchor;
		logic [31:0] older;
		logic [31:0] newer;

		tpa_pkg::tpa_result_t pending_tris[$];

		int fail_count;
		int tri_count;
		int err_count;
		int index_count;

		function new();
			mode   = tpa_pkg::MODE_LIST;
			flip   = 1'b0;
			vcount = '0;
			vbase  = '0;
			clear_assembly();
		endfunction

		function void clear_assembly();
			seen     = '0;
			phase    = '0;
			parity   = 1'b0;
			err_mark = 1'b0;
			anchor   = '0;
			older    = '0;
			newer    = '0;
		endfunction

		function void write_reg(logic [1:0] r, logic [31:0] d);
			case (r)
				tpa_pkg::CFG_TOPOLOGY_MODE: mode = d[2:0];
				tpa_pkg::CFG_WINDING_FLIP: flip = d[0];
				tpa_pkg::CFG_VTX_LIMIT: vcount = d;
				tpa_pkg::CFG_VERTEX_BASE: vbase = d;
				default: ;
			endcase
		endfunction

		function bit assembling();
			return mode == tpa_pkg::MODE_LIST || mode == tpa_pkg::MODE_STRIP ||
				mode == tpa_pkg::MODE_FAN;
		endfunction

		// flip, degenerate drop, base add
		function void add_triangle(logic [31:0] a, logic [31:0] b, logic [31:0] c);
			logic [31:0] t;
			tpa_pkg::tpa_result_t r;
			if (flip) begin
				t = b;
				b = c;
				c = t;
			end
			if (a == b || b == c || c == a)
				return;
			r.err = 1'b0;
			r.a   = a + vbase;
			r.b   = b + vbase;
			r.c   = c + vbase;
			pending_tris.push_back(r);
			tri_count++;
		endfunction

		function void take_index(logic [31:0] v, logic first);
			logic [63:0] mask;
			logic [31:0] idx;
			logic [31:0] a;
			logic [31:0] b;
			tpa_pkg::tpa_result_t r;
			mask = (64'd1 << INDEX_BITS) - 64'd1;
			idx = v & mask[31:0];
			index_count++;
			if (first)
				clear_assembly();
			if (!assembling() || err_mark)
				return;
			if (idx >= vcount) begin
				err_mark = 1'b1;
				r = '0;
				r.err = 1'b1;
				pending_tris.push_back(r);
				err_count++;
				return;
			end
			if (mode == tpa_pkg::MODE_LIST) begin
				if (phase == 2'd0) begin
					older = idx;
					phase = 2'd1;
				end else if (phase == 2'd1) begin
					newer = idx;
					phase = 2'd2;
				end else begin
					phase = 2'd0;
					add_triangle(older, newer, idx);
				end
			end else if (seen == 2'd0) begin
				if (mode == tpa_pkg::MODE_STRIP)
					older = idx;
				else
					anchor = idx;
				seen = 2'd1;
			end else if (seen == 2'd1) begin
				newer = idx;
				seen = 2'd2;
			end else if (mode == tpa_pkg::MODE_STRIP) begin
				a = parity ? newer : older;
				b = parity ? older : newer;
				parity = ~parity;
				older = newer;
				newer = idx;
				add_triangle(a, b, idx);
			end else begin
				b = newer;
				older = newer;
				newer = idx;
				add_triangle(anchor, b, idx);
			end
		endfunction

		task report(string what, logic [31:0] want, logic [31:0] got);
			fail_count++;
			if (fail_count <= 40)
				$display("mismatch %s: expected %h, got %h", what, want, got);
		endtask

		task check_triangle(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic err);
			tpa_pkg::tpa_result_t want;
			if (pending_tris.size() == 0) begin
				report("unexpected result, corner_a", 32'd0, a);
				return;
			end
			want = pending_tris.pop_front();
			if (err !== want.err)
				report("index_error", {31'd0, want.err}, {31'd0, err});
			if (a !== want.a)
				report("corner_a", want.a, a);
			if (b !== want.b)
				report("corner_b", want.b, b);
			if (c !== want.c)
				report("corner_c", want.c, c);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [31:0] index_value;
	logic        first_of_primitive;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] corner_a;
	logic [31:0] corner_b;
	logic [31:0] corner_c;
	logic        index_error;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	triangle_board board = new();

	bit          push_steady;  // no sender gaps in this stretch
	bit          pop_steady;   // no receiver stalls in this stretch
	int          pop_hold;
	int          idle_cycles;
	int          active_items;
	int          setting_count;
	logic [31:0] last_idx;

	triangle_primitive_assembly_top #(
		.INDEX_BITS(INDEX_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.index_value(index_value),
		.first_of_primitive(first_of_primitive),
		.empty(empty),
		.pop(pop),
		.corner_a(corner_a),
		.corner_b(corner_b),
		.corner_c(corner_c),
		.index_error(index_error),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// All handshakes are sampled at the edge, before any NBA of that edge
	// lands, so driver and DUT see the same values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
			if (pop && !empty)
				board.check_triangle(corner_a, corner_b, corner_c, index_error);
			if (push && !full)
				board.take_index(index_value, first_of_primitive);
		end
	end

	// Receiver: random stalls, with occasional stretches of none.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			pop_steady = !pop_steady;
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if (!pop_steady && $urandom_range(0, 2) == 0)
				pop_hold = pick_gap();
		end
	end

	// Stops the run when nothing moves for too long.
	initial begin : watchdog
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// push stays high on return so back-to-back requests need no re-raise
	task automatic send_index(input logic [31:0] v, input logic f);
		push <= 1'b1;
		index_value <= v;
		first_of_primitive <= f;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic offer(input logic [31:0] v, input logic f);
		int gap;
		send_index(v, f);
		last_idx = v;
		gap = push_steady ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every pending result has been popped, then give requests
	// that produce nothing time to clear the pipe.
	task automatic drain_block();
		push <= 1'b0;
		do begin
			while (board.pending_tris.size() != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end while (board.pending_tris.size() != 0);
	endtask

	task automatic cfg_request(input logic [1:0] r, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// Only called with the block idle; all four registers in one burst.
	task automatic write_setup(input logic [2:0] m, input logic f,
			input logic [31:0] n, input logic [31:0] b);
		drain_block();
		cfg_request(CFG_TOPOLOGY_MODE, {29'd0, m});
		cfg_request(CFG_WINDING_FLIP, {31'd0, f});
		cfg_request(CFG_VTX_LIMIT, n);
		cfg_request(CFG_VERTEX_BASE, b);
		cfg_valid <= 1'b0;
		setting_count++;
	endtask

	// Mostly in range, with noise, boundary hits and repeats for
	// degenerate triangles.
	function automatic logic [31:0] pick_index(input logic [31:0] n);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return $urandom;
		if (r < 8)
			return n;
		if (r < 11 && n != 0)
			return n - 32'd1;
		if (r < 25)
			return last_idx;
		if (n == 0)
			return $urandom;
		return $urandom_range(n - 32'd1, 0);
	endfunction

	function automatic logic [31:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(40, 1);
		if (r < 75)
			return 32'd0;
		if (r < 85)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_base();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom;
		if (r < 60)
			return 32'd0;
		if (r < 80)
			return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFC0);
		return $urandom_range(255, 1);
	endfunction

	initial begin : stimulus
		logic [2:0]  m;
		logic [31:0] n;
		int          phase_items;
		int          sent;
		int          len;
		bit          pause_mid;
		bit          paused_once;

		arst_n <= 1'b0;
		push <= 1'b0;
		index_value <= '0;
		first_of_primitive <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_TOPOLOGY_MODE;
		cfg_data <= '0;
		push_steady = 1'b0;
		last_idx = '0;
		paused_once = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// Reset setting: list with no vertices, so the first index errors and
		// the rest of the primitive is ignored.
		offer(32'd0, 1'b1);
		offer(32'hFFFF_FFFF, 1'b0);

		// List with the largest vertex limit and a base that wraps the sum.
		write_setup(MODE_LIST, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
		offer(32'd0, 1'b1);
		offer(32'd1, 1'b0);
		offer(32'hFFFF_FFFE, 1'b0);
		offer(32'd3, 1'b0);      // repeated corner, dropped
		offer(32'd3, 1'b0);
		offer(32'd4, 1'b0);
		offer(32'hFFFF_FFFF, 1'b0); // equal to count: error
		offer(32'd6, 1'b0);      // silenced by error mark
		offer(32'd7, 1'b1);      // trailing pair, never completes
		offer(32'd8, 1'b0);

		// Strip with flip, no restart: list phase is left as it stands.
		write_setup(MODE_STRIP, 1'b1, 32'd10, 32'd0);
		offer(32'd1, 1'b0);
		offer(32'd2, 1'b0);
		offer(32'd3, 1'b0);
		offer(32'd2, 1'b0);      // degenerate, parity still moves
		offer(32'd4, 1'b0);
		offer(32'd10, 1'b0);     // out of range
		offer(32'd5, 1'b0);

		write_setup(MODE_FAN, 1'b0, 32'd8, 32'd100);
		offer(32'd2, 1'b1);
		offer(32'd3, 1'b0);
		offer(32'd4, 1'b0);
		offer(32'd4, 1'b0);      // repeats previous corner
		offer(32'd0, 1'b0);

		// A mode with no topology: nothing checked, nothing out.
		write_setup(3'd7, 1'b1, 32'd8, 32'd0);
		offer(32'd1, 1'b1);
		offer(32'd2, 1'b0);
		offer(32'd3, 1'b0);

		// --- random settings, each followed by a stretch of primitives ---
		active_items = 0;
		while (active_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 85)
				m = 3'($urandom_range(6, 4));
			else
				m = 3'($urandom_range(7, 0));
			n = pick_count();
			write_setup(m, 1'($urandom_range(1, 0)), n, pick_base());
			push_steady = ($urandom_range(0, 3) == 0);
			phase_items = $urandom_range(120, 20);
			pause_mid = !paused_once || ($urandom_range(0, 9) == 0);
			sent = 0;
			while (sent < phase_items) begin
				if (m == MODE_LIST)
					len = 3 * $urandom_range(6, 1) +
						(($urandom_range(0, 4) == 0) ? $urandom_range(2, 1) : 0);
				else
					len = $urandom_range(12, 1);
				for (int k = 0; k < len; k++) begin
					// a few primitives run on without a restart
					offer(pick_index(n), (k == 0) && ($urandom_range(0, 9) != 0));
					sent++;
				end
				// sender holds off until the result queue has run dry
				if (pause_mid && sent >= phase_items / 2) begin
					drain_block();
					pause_mid = 1'b0;
					paused_once = 1'b1;
				end
			end
			active_items += sent;
		end

		drain_block();
		repeat (20) @(posedge clk);
		if (board.pending_tris.size() != 0)
			board.report("results never popped", 32'd0, board.pending_tris.size());

		$display("ran %0d indices over %0d register settings: %0d triangles, %0d errors",
			board.index_count, setting_count, board.tri_count, board.err_count);
		$display("list, strip, fan and inert modes, flip, base wrap, drops and restarts");
		if (board.fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
